[hdl/alle_pkg.sv]
// shared types, constants and codes of the linked list engine
package alle_pkg;

	// pool and field geometry
	localparam int POOL_SIZE = 64;
	localparam int SLOT_W    = $clog2(POOL_SIZE);
	localparam int LINK_W    = SLOT_W + 1;
	localparam int USED_W    = SLOT_W + 1;
	localparam int TEXT_W    = 56;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 3;

	// longest traversal before it is cut
	localparam int DEPTH     = 64;
	localparam int TRV_CNT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// command queue between front and back
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// end of list marker, normalized
	localparam logic [LINK_W-1:0] END_LINK = '1;

	typedef enum logic [OP_W-1:0] {
		OP_RESTART  = 3'd0,
		OP_LOAD     = 3'd1,
		OP_INSERT   = 3'd2,
		OP_DELETE   = 3'd3,
		OP_TRAVERSE = 3'd4
	} op_e;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 3'd0,
		STS_FULL  = 3'd1,
		STS_NONE  = 3'd2,
		STS_CUT   = 3'd3,
		STS_EMPTY = 3'd4
	} sts_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_WR1,
		S_INS_WR2,
		S_DEL_FIND,
		S_DEL_GET,
		S_TRV,
		S_REPLY
	} state_e;

	// one classified command
	typedef struct packed {
		op_e               op;
		logic              at_head;
		logic [SLOT_W-1:0] position;
		logic [TEXT_W-1:0] text;
		logic [LINK_W-1:0] link;
	} cmd_t;

endpackage

[hdl/alle_if.sv]
// request and result channel interfaces of the linked list engine
interface alle_in_if;
	logic                           valid;
	logic                           ready;
	logic [alle_pkg::OP_W-1:0]      operation;
	logic                           at_head;
	logic [alle_pkg::SLOT_W-1:0]    position;
	logic [alle_pkg::TEXT_W-1:0]    text;
	logic signed [alle_pkg::LINK_W-1:0] link;

	modport source (output valid, operation, at_head, position, text, link, input ready);
	modport sink (input valid, operation, at_head, position, text, link, output ready);
endinterface

interface alle_out_if;
	logic                           valid;
	logic                           ready;
	logic [alle_pkg::SLOT_W-1:0]    slot;
	logic [alle_pkg::TEXT_W-1:0]    entry_text;
	logic [alle_pkg::STATUS_W-1:0]  status;
	logic                           last;

	modport source (output valid, slot, entry_text, status, last, input ready);
	modport sink (input valid, slot, entry_text, status, last, output ready);
endinterface

[hdl/alle_ram.sv]
// generic single write port ram with registered read
module alle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and read-first registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/alle_front.sv]
// front part: accepts request items, classifies them and queues commands
module alle_front (
	input  logic           clk,
	input  logic           arst_n,
	alle_in_if.sink        req,
	output logic           cmd_valid,
	output alle_pkg::cmd_t cmd,
	input  logic           cmd_pop
);

	logic [alle_pkg::CMDQ_CNT_W-1:0] cnt_q;
	logic [alle_pkg::CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [alle_pkg::CMDQ_PTR_W-1:0] rd_ptr_q;
	alle_pkg::cmd_t                  q_mem_q [alle_pkg::CMDQ_DEPTH];
	alle_pkg::cmd_t                  cmd_new;
	logic                            known;
	logic                            push;
	logic                            pop;

	// classify the incoming item, unknown operations are dropped
	assign known = req.operation inside {[alle_pkg::OP_RESTART:alle_pkg::OP_TRAVERSE]};
	assign req.ready = (cnt_q != alle_pkg::CMDQ_CNT_W'(alle_pkg::CMDQ_DEPTH));
	assign push = req.valid && req.ready && known;
	assign pop = cmd_pop && cmd_valid;

	// normalize the link: any negative value is the end mark
	always_comb begin
		cmd_new.op       = alle_pkg::op_e'(req.operation);
		cmd_new.at_head  = req.at_head;
		cmd_new.position = req.position;
		cmd_new.text     = req.text;
		cmd_new.link     = req.link[alle_pkg::LINK_W-1] ? alle_pkg::END_LINK : req.link;
	end

	// queue head to the back part
	assign cmd_valid = (cnt_q != '0);
	assign cmd = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd_new;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_cmdq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= alle_pkg::CMDQ_CNT_W'(alle_pkg::CMDQ_DEPTH))
		else $error("command queue overfilled");
`endif

endmodule

[hdl/alle_back.sv]
// back part: carries out list commands on the slot memories
module alle_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  alle_pkg::cmd_t cmd,
	output logic           cmd_pop,
	alle_out_if.source     rsp
);

	localparam int SW = alle_pkg::SLOT_W;
	localparam int LW = alle_pkg::LINK_W;
	localparam int TW = alle_pkg::TEXT_W;
	localparam int CW = alle_pkg::TRV_CNT_W;

	alle_pkg::state_e          state_q, state_d;
	alle_pkg::cmd_t            cmd_q;
	logic [LW-1:0]             head_q, head_d;
	logic [alle_pkg::USED_W-1:0] used_q, used_d;
	logic [SW-1:0]             cur_q, cur_d;
	logic [CW-1:0]             cnt_q, cnt_d;
	logic [SW-1:0]             victim_q, victim_d;
	logic [SW-1:0]             res_slot_q, res_slot_d;
	logic [TW-1:0]             res_text_q, res_text_d;
	alle_pkg::sts_e            res_status_q, res_status_d;

	// output register
	logic                      ovalid_q;
	logic [SW-1:0]             oslot_q;
	logic [TW-1:0]             otext_q;
	alle_pkg::sts_e            ostatus_q;
	logic                      olast_q;

	logic                      push;
	logic [SW-1:0]             push_slot;
	logic [TW-1:0]             push_text;
	alle_pkg::sts_e            push_status;
	logic                      push_last;
	logic                      can_push;

	// memory ports
	logic [SW-1:0]             raddr;
	logic                      t_we;
	logic [SW-1:0]             t_waddr;
	logic [TW-1:0]             t_wdata;
	logic [TW-1:0]             rd_text;
	logic                      n_we;
	logic [SW-1:0]             n_waddr;
	logic [LW-1:0]             n_wdata;
	logic [LW-1:0]             rd_next;

	logic                      full;
	logic [SW-1:0]             fresh;
	logic                      head_end;
	logic                      cnt_max;
	logic                      trv_final;

	alle_ram #(.WIDTH(TW), .DEPTH(alle_pkg::POOL_SIZE)) u_text_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (raddr),
		.rdata (rd_text)
	);

	alle_ram #(.WIDTH(LW), .DEPTH(alle_pkg::POOL_SIZE)) u_next_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.raddr (raddr),
		.rdata (rd_next)
	);

	// shared conditions
	assign full      = (used_q == alle_pkg::USED_W'(alle_pkg::POOL_SIZE));
	assign fresh     = used_q[SW-1:0];
	assign head_end  = head_q[LW-1];
	assign cnt_max   = (cnt_q == CW'(alle_pkg::DEPTH - 1));
	assign trv_final = rd_next[LW-1] || cnt_max;
	assign can_push  = !ovalid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			alle_pkg::S_IDLE: begin
				if (cmd_valid) begin
					state_d = alle_pkg::S_DISPATCH;
				end
			end
			alle_pkg::S_DISPATCH: begin
				case (cmd_q.op)
					alle_pkg::OP_RESTART, alle_pkg::OP_LOAD: state_d = alle_pkg::S_REPLY;
					alle_pkg::OP_INSERT: begin
						state_d = (full || cmd_q.at_head) ? alle_pkg::S_REPLY
							: alle_pkg::S_INS_WR1;
					end
					alle_pkg::OP_DELETE: begin
						if (!cmd_q.at_head) begin
							state_d = alle_pkg::S_DEL_FIND;
						end else begin
							state_d = head_end ? alle_pkg::S_REPLY : alle_pkg::S_DEL_GET;
						end
					end
					alle_pkg::OP_TRAVERSE: begin
						state_d = head_end ? alle_pkg::S_REPLY : alle_pkg::S_TRV;
					end
					default: state_d = alle_pkg::S_IDLE;
				endcase
			end
			alle_pkg::S_INS_WR1: state_d = alle_pkg::S_INS_WR2;
			alle_pkg::S_INS_WR2: state_d = alle_pkg::S_REPLY;
			alle_pkg::S_DEL_FIND: begin
				state_d = rd_next[LW-1] ? alle_pkg::S_REPLY : alle_pkg::S_DEL_GET;
			end
			alle_pkg::S_DEL_GET: state_d = alle_pkg::S_REPLY;
			alle_pkg::S_TRV: begin
				if (can_push && trv_final) begin
					state_d = alle_pkg::S_IDLE;
				end
			end
			alle_pkg::S_REPLY: begin
				if (can_push) begin
					state_d = alle_pkg::S_IDLE;
				end
			end
			default: state_d = alle_pkg::S_IDLE;
		endcase
	end

	// datapath control and register updates
	always_comb begin
		cmd_pop      = 1'b0;
		raddr        = cur_q;
		t_we         = 1'b0;
		t_waddr      = fresh;
		t_wdata      = cmd_q.text;
		n_we         = 1'b0;
		n_waddr      = fresh;
		n_wdata      = cmd_q.link;
		head_d       = head_q;
		used_d       = used_q;
		cur_d        = cur_q;
		cnt_d        = cnt_q;
		victim_d     = victim_q;
		res_slot_d   = res_slot_q;
		res_text_d   = res_text_q;
		res_status_d = res_status_q;
		push         = 1'b0;
		push_slot    = res_slot_q;
		push_text    = res_text_q;
		push_status  = res_status_q;
		push_last    = 1'b1;
		case (state_q)
			alle_pkg::S_IDLE: begin
				cmd_pop = cmd_valid;
			end
			alle_pkg::S_DISPATCH: begin
				res_slot_d   = '0;
				res_text_d   = '0;
				res_status_d = alle_pkg::STS_OK;
				case (cmd_q.op)
					alle_pkg::OP_RESTART: begin
						head_d = cmd_q.link;
						used_d = '0;
					end
					alle_pkg::OP_LOAD, alle_pkg::OP_INSERT: begin
						if (full) begin
							res_status_d = alle_pkg::STS_FULL;
						end else if (cmd_q.op == alle_pkg::OP_LOAD || cmd_q.at_head) begin
							// new slot written in one go
							t_we       = 1'b1;
							n_we       = 1'b1;
							n_wdata    = (cmd_q.op == alle_pkg::OP_LOAD) ? cmd_q.link : head_q;
							used_d     = used_q + 1'b1;
							res_slot_d = fresh;
							if (cmd_q.op == alle_pkg::OP_INSERT) begin
								head_d = {1'b0, fresh};
							end
						end else begin
							raddr = cmd_q.position;
						end
					end
					alle_pkg::OP_DELETE: begin
						if (!cmd_q.at_head) begin
							raddr = cmd_q.position;
						end else if (head_end) begin
							res_status_d = alle_pkg::STS_NONE;
						end else begin
							raddr    = head_q[SW-1:0];
							victim_d = head_q[SW-1:0];
						end
					end
					alle_pkg::OP_TRAVERSE: begin
						if (head_end) begin
							res_status_d = alle_pkg::STS_EMPTY;
						end else begin
							raddr = head_q[SW-1:0];
							cur_d = head_q[SW-1:0];
							cnt_d = '0;
						end
					end
					default: ;
				endcase
			end
			alle_pkg::S_INS_WR1: begin
				// new slot takes the old successor of position
				t_we    = 1'b1;
				n_we    = 1'b1;
				n_wdata = rd_next;
			end
			alle_pkg::S_INS_WR2: begin
				// position now points at the new slot
				n_we       = 1'b1;
				n_waddr    = cmd_q.position;
				n_wdata    = {1'b0, fresh};
				used_d     = used_q + 1'b1;
				res_slot_d = fresh;
			end
			alle_pkg::S_DEL_FIND: begin
				if (rd_next[LW-1]) begin
					res_status_d = alle_pkg::STS_NONE;
				end else begin
					raddr    = rd_next[SW-1:0];
					victim_d = rd_next[SW-1:0];
				end
			end
			alle_pkg::S_DEL_GET: begin
				// bypass the victim and report its text
				if (cmd_q.at_head) begin
					head_d = rd_next;
				end else begin
					n_we    = 1'b1;
					n_waddr = cmd_q.position;
					n_wdata = rd_next;
				end
				res_slot_d   = victim_q;
				res_text_d   = rd_text;
				res_status_d = alle_pkg::STS_OK;
			end
			alle_pkg::S_TRV: begin
				// one entry per cycle while rsp is not stalled, next read issued as the current one leaves
				if (can_push) begin
					push        = 1'b1;
					push_slot   = cur_q;
					push_text   = rd_text;
					push_status = (cnt_max && !rd_next[LW-1]) ? alle_pkg::STS_CUT
						: alle_pkg::STS_OK;
					push_last   = trv_final;
					if (!trv_final) begin
						raddr = rd_next[SW-1:0];
						cur_d = rd_next[SW-1:0];
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			alle_pkg::S_REPLY: begin
				push = can_push;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= alle_pkg::S_IDLE;
			head_q   <= alle_pkg::END_LINK;
			used_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			used_q  <= used_d;
			if (push) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		cur_q        <= cur_d;
		cnt_q        <= cnt_d;
		victim_q     <= victim_d;
		res_slot_q   <= res_slot_d;
		res_text_q   <= res_text_d;
		res_status_q <= res_status_d;
		if (push) begin
			oslot_q   <= push_slot;
			otext_q   <= push_text;
			ostatus_q <= push_status;
			olast_q   <= push_last;
		end
	end

	// result channel
	assign rsp.valid      = ovalid_q;
	assign rsp.slot       = oslot_q;
	assign rsp.entry_text = otext_q;
	assign rsp.status     = ostatus_q;
	assign rsp.last       = olast_q;

`ifndef ASSERT_OFF
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= alle_pkg::USED_W'(alle_pkg::POOL_SIZE))
		else $error("slot counter beyond pool size");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		t_we |-> !full)
		else $error("text written into a full pool");

	a_head_normalized: assert property (@(posedge clk) disable iff (!arst_n)
		head_q[LW-1] |-> (head_q == alle_pkg::END_LINK))
		else $error("head holds an unnormalized end mark");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!ovalid_q || rsp.ready))
		else $error("result pushed over a pending result");
`endif

endmodule

[hdl/array_linked_list_engine_core.sv]
// top level of the array backed singly linked list engine
// usage:
//   req carries one command item per valid/ready handshake: restart, load slot,
//   insert, delete or traverse over a pool of 64 slots; codes 5 to 7 are dropped
//   without a result. rsp carries result items; last marks the final result of
//   a command. A two entry command queue sits in front of the executing
//   sequencer; req stays ready through sequencer or rsp stalls until the queue fills.
// steps: the sequencer pops each command in idle and decodes it in dispatch;
//   restart, load and insert at head then reply. Insert after a slot reads its
//   link, writes the new slot, then relinks the slot, as the slot memories have
//   a single write port and a registered read. Delete finds the victim (after a
//   slot by reading that slot's link), bypasses it and replies; traverse emits
//   its entries in turn, pausing while rsp stalls. A full pool, an empty list or
//   a missing victim ends in a reply. Each result shows on rsp the cycle after
//   the sequencer cycle that makes it; commands wait queued until idle pops them.
// reset: arst_n clears the queue, the result valid flag and the sequencer, and
//   sets an empty list with no slots in use; slot contents are not cleared.
// stall: a held rsp.ready holds the result register; traversal pauses on the
//   current entry, and once the queue is full req.ready drops.
module array_linked_list_engine_core (
	input  logic       clk,
	input  logic       arst_n,
	alle_in_if.sink    req,
	alle_out_if.source rsp
);

	alle_pkg::cmd_t cmd;
	logic           cmd_valid;
	logic           cmd_pop;

	alle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	alle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp)
	);

endmodule
